@@ rtl/core/keepalive_timeout_table_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef KEEPALIVE_TIMEOUT_TABLE_CORE_MACROS_SVH
`define KEEPALIVE_TIMEOUT_TABLE_CORE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define KAT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kat assertion failed");

// Check that a stalled word holds its valid and its payload.
`define KAT_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error("kat stalled word changed");

`endif

@@ rtl/core/kat_pkg.sv @@
package kat_pkg;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int ID_W    = 32;
  localparam int LIM_W   = 16;
  localparam int HDL_W   = 64;
  localparam int STS_W   = 3;
  localparam int COUNT_W = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd4;

  // Result status codes
  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd1;
  localparam logic [STS_W-1:0] STS_FULL      = 3'd2;
  localparam logic [STS_W-1:0] STS_PRESENT   = 3'd3;
  localparam logic [STS_W-1:0] STS_EMPTY     = 3'd4;
  localparam logic [STS_W-1:0] STS_EXPIRED   = 3'd5;

  localparam logic [LIM_W-1:0] ELAPSED_MAX = '1;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [ID_W-1:0]  peer;
    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] elapsed;
    logic [HDL_W-1:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Write data selection
  typedef enum logic [1:0] {
    WR_NEW,
    WR_COPY,
    WR_REFRESH,
    WR_TICK
  } wsel_e;

  // Kind of result word to build
  typedef enum logic [1:0] {
    RES_SINGLE,
    RES_EXPIRED,
    RES_CLOSE
  } res_kind_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load;
    logic             cap;
    logic             idx_inc;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             xcnt_inc;
    logic             rd_tail;
    logic             we;
    logic             wa_count;
    wsel_e            wsel;
    logic             emit;
    res_kind_e        res_kind;
    logic [STS_W-1:0] res_status;
    logic             with_handle;
  } dp_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             at_end;
    logic             match;
    logic             expired;
    logic             out_free;
  } dp_sts_t;

endpackage

@@ rtl/core/kat_if.sv @@
// Input channel
interface kat_in_if;
  logic                        valid;
  logic                        ready;
  logic [kat_pkg::CMD_W-1:0]   command;
  logic [kat_pkg::ID_W-1:0]    peer_id;
  logic [kat_pkg::LIM_W-1:0]   timeout_limit;
  logic [kat_pkg::HDL_W-1:0]   timer_handle;
  logic [kat_pkg::LIM_W-1:0]   tick_delta;

  modport source (output valid, command, peer_id, timeout_limit, timer_handle, tick_delta,
                  input ready);
  modport sink (input valid, command, peer_id, timeout_limit, timer_handle, tick_delta,
                output ready);
endinterface

// Result channel
interface kat_out_if;
  logic                        valid;
  logic                        ready;
  logic [kat_pkg::STS_W-1:0]   status;
  logic [kat_pkg::ID_W-1:0]    result_peer;
  logic [kat_pkg::HDL_W-1:0]   result_handle;
  logic [kat_pkg::COUNT_W-1:0] expired_count;
  logic                        last;

  modport source (output valid, status, result_peer, result_handle, expired_count, last,
                  input ready);
  modport sink (input valid, status, result_peer, result_handle, expired_count, last,
                output ready);
endinterface

@@ rtl/core/kat_ram.sv @@
module kat_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/kat_ctrl.sv @@
module kat_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kat_pkg::dp_sts_t sts_i,
  output kat_pkg::dp_ctl_t ctl_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_MOVE  = 4'd4;
  localparam logic [3:0] S_EMIT  = 4'd5;
  localparam logic [3:0] S_TRD   = 4'd6;
  localparam logic [3:0] S_TCMP  = 4'd7;
  localparam logic [3:0] S_TEXP  = 4'd8;
  localparam logic [3:0] S_CLOSE = 4'd9;

  logic [3:0]                 state_q, state_d;
  logic [kat_pkg::STS_W-1:0]  res_status_q, res_status_d;
  logic                       with_handle_q, with_handle_d;

  // Sequence one command through the table
  always_comb begin
    state_d       = state_q;
    res_status_d  = res_status_q;
    with_handle_d = with_handle_q;
    in_ready_o    = 1'b0;
    ctl_o         = '0;
    ctl_o.wsel    = kat_pkg::WR_NEW;
    ctl_o.res_kind = kat_pkg::RES_SINGLE;
    ctl_o.res_status  = res_status_q;
    ctl_o.with_handle = with_handle_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load    = 1'b1;
          with_handle_d = 1'b0;
          state_d       = S_START;
        end
      end

      S_START: begin
        case (sts_i.cmd)
          kat_pkg::CMD_ADD: begin
            if (sts_i.full) begin
              res_status_d = kat_pkg::STS_FULL;
              state_d      = S_EMIT;
            end else begin
              state_d = S_SCAN;
            end
          end
          kat_pkg::CMD_DELETE, kat_pkg::CMD_REFRESH, kat_pkg::CMD_LOOKUP: begin
            state_d = S_SCAN;
          end
          kat_pkg::CMD_TICK: begin
            if (sts_i.empty) begin
              res_status_d = kat_pkg::STS_EMPTY;
              state_d      = S_EMIT;
            end else begin
              state_d = S_TRD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      // Read the entry at the index, or finish a search that found nothing
      S_SCAN: begin
        if (sts_i.at_end) begin
          if (sts_i.cmd == kat_pkg::CMD_ADD) begin
            ctl_o.we       = 1'b1;
            ctl_o.wa_count = 1'b1;
            ctl_o.wsel     = kat_pkg::WR_NEW;
            ctl_o.cnt_inc  = 1'b1;
            res_status_d   = kat_pkg::STS_OK;
          end else begin
            res_status_d = kat_pkg::STS_NOT_FOUND;
          end
          state_d = S_EMIT;
        end else begin
          state_d = S_CMP;
        end
      end

      // Compare the read id and act on a hit
      S_CMP: begin
        ctl_o.cap = 1'b1;
        if (sts_i.match) begin
          case (sts_i.cmd)
            kat_pkg::CMD_ADD: begin
              res_status_d = kat_pkg::STS_PRESENT;
              state_d      = S_EMIT;
            end
            kat_pkg::CMD_DELETE: begin
              ctl_o.rd_tail = 1'b1;
              state_d       = S_MOVE;
            end
            kat_pkg::CMD_REFRESH: begin
              ctl_o.we     = 1'b1;
              ctl_o.wsel   = kat_pkg::WR_REFRESH;
              res_status_d = kat_pkg::STS_OK;
              state_d      = S_EMIT;
            end
            kat_pkg::CMD_LOOKUP: begin
              res_status_d  = kat_pkg::STS_OK;
              with_handle_d = 1'b1;
              state_d       = S_EMIT;
            end
            default: state_d = S_IDLE;
          endcase
        end else begin
          ctl_o.idx_inc = 1'b1;
          state_d       = S_SCAN;
        end
      end

      // Move the last entry into the freed slot
      S_MOVE: begin
        ctl_o.we      = 1'b1;
        ctl_o.wsel    = kat_pkg::WR_COPY;
        ctl_o.cnt_dec = 1'b1;
        res_status_d  = kat_pkg::STS_OK;
        state_d       = S_EMIT;
      end

      S_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.res_kind = kat_pkg::RES_SINGLE;
          state_d        = S_IDLE;
        end
      end

      // Tick walk: read each entry, update, report
      S_TRD: begin
        state_d = sts_i.at_end ? S_CLOSE : S_TCMP;
      end

      S_TCMP: begin
        ctl_o.cap  = 1'b1;
        ctl_o.we   = 1'b1;
        ctl_o.wsel = kat_pkg::WR_TICK;
        if (sts_i.expired) begin
          ctl_o.xcnt_inc = 1'b1;
          state_d        = S_TEXP;
        end else begin
          ctl_o.idx_inc = 1'b1;
          state_d       = S_TRD;
        end
      end

      S_TEXP: begin
        if (sts_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.res_kind = kat_pkg::RES_EXPIRED;
          ctl_o.idx_inc  = 1'b1;
          state_d        = S_TRD;
        end
      end

      S_CLOSE: begin
        if (sts_i.out_free) begin
          ctl_o.emit     = 1'b1;
          ctl_o.res_kind = kat_pkg::RES_CLOSE;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      res_status_q  <= kat_pkg::STS_OK;
      with_handle_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      res_status_q  <= res_status_d;
      with_handle_q <= with_handle_d;
    end
  end

endmodule

@@ rtl/core/kat_datapath.sv @@
module kat_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kat_pkg::dp_ctl_t            ctl_i,
  output kat_pkg::dp_sts_t            sts_o,
  input  logic [kat_pkg::CMD_W-1:0]   command_i,
  input  logic [kat_pkg::ID_W-1:0]    peer_id_i,
  input  logic [kat_pkg::LIM_W-1:0]   timeout_limit_i,
  input  logic [kat_pkg::HDL_W-1:0]   timer_handle_i,
  input  logic [kat_pkg::LIM_W-1:0]   tick_delta_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [kat_pkg::STS_W-1:0]   status_o,
  output logic [kat_pkg::ID_W-1:0]    result_peer_o,
  output logic [kat_pkg::HDL_W-1:0]   result_handle_o,
  output logic [kat_pkg::COUNT_W-1:0] expired_count_o,
  output logic                        last_o
);

  localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [kat_pkg::COUNT_W-1:0] CapCount = kat_pkg::COUNT_W'(CAPACITY);

  // Latched command word
  logic [kat_pkg::CMD_W-1:0]   cmd_q;
  logic [kat_pkg::ID_W-1:0]    id_q;
  logic [kat_pkg::LIM_W-1:0]   lim_q;
  logic [kat_pkg::HDL_W-1:0]   hdl_q;
  logic [kat_pkg::LIM_W-1:0]   delta_q;

  logic [kat_pkg::COUNT_W-1:0] count_q, idx_q, xcnt_q;
  logic [kat_pkg::COUNT_W-1:0] tail;
  kat_pkg::entry_t             ent_q;

  logic [AddrW-1:0]            raddr, waddr;
  logic [kat_pkg::ENTRY_W-1:0] rdata_raw;
  kat_pkg::entry_t             rd, wr;
  logic [kat_pkg::LIM_W:0]     sum;
  logic [kat_pkg::LIM_W-1:0]   sat_elapsed;

  logic                        out_valid_q;
  logic [kat_pkg::STS_W-1:0]   out_status_q;
  logic [kat_pkg::ID_W-1:0]    out_peer_q;
  logic [kat_pkg::HDL_W-1:0]   out_handle_q;
  logic [kat_pkg::COUNT_W-1:0] out_count_q;
  logic                        out_last_q;
  logic [kat_pkg::STS_W-1:0]   res_status;
  logic [kat_pkg::ID_W-1:0]    res_peer;
  logic [kat_pkg::HDL_W-1:0]   res_handle;
  logic [kat_pkg::COUNT_W-1:0] res_count;
  logic                        res_last;

  // Hold the command word for the whole walk, and capture the read entry on cap
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= command_i;
      id_q    <= peer_id_i;
      lim_q   <= timeout_limit_i;
      hdl_q   <= timer_handle_i;
      delta_q <= tick_delta_i;
    end
    if (ctl_i.cap) begin
      ent_q <= rd;
    end
  end

  // Fill count, walk index and expiry counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      xcnt_q  <= '0;
    end else begin
      if (ctl_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (ctl_i.cnt_dec) begin
        count_q <= tail;
      end
      if (ctl_i.load) begin
        idx_q  <= '0;
        xcnt_q <= '0;
      end else begin
        if (ctl_i.idx_inc) begin
          idx_q <= idx_q + 1'b1;
        end
        if (ctl_i.xcnt_inc) begin
          xcnt_q <= xcnt_q + 1'b1;
        end
      end
    end
  end

  assign tail  = count_q - 1'b1;
  assign raddr = ctl_i.rd_tail ? tail[AddrW-1:0] : idx_q[AddrW-1:0];
  assign waddr = ctl_i.wa_count ? count_q[AddrW-1:0] : idx_q[AddrW-1:0];
  assign rd    = kat_pkg::entry_t'(rdata_raw);

  // Saturating elapsed update
  assign sum         = {1'b0, rd.elapsed} + {1'b0, delta_q};
  assign sat_elapsed = sum[kat_pkg::LIM_W] ? kat_pkg::ELAPSED_MAX : sum[kat_pkg::LIM_W-1:0];

  // Select the word to write back
  always_comb begin
    wr = rd;
    case (ctl_i.wsel)
      kat_pkg::WR_NEW: begin
        wr.peer    = id_q;
        wr.limit   = lim_q;
        wr.elapsed = '0;
        wr.handle  = hdl_q;
      end
      kat_pkg::WR_COPY:    wr = rd;
      kat_pkg::WR_REFRESH: wr.elapsed = '0;
      kat_pkg::WR_TICK:    wr.elapsed = sat_elapsed;
      default:             wr = rd;
    endcase
  end

  kat_ram #(
    .Width (kat_pkg::ENTRY_W),
    .Depth (CAPACITY)
  ) u_kat_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.we),
    .waddr_i (waddr),
    .wdata_i (wr),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  // Status back to the controller
  assign sts_o.cmd      = cmd_q;
  assign sts_o.full     = (count_q >= CapCount);
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.at_end   = (idx_q == count_q);
  assign sts_o.match    = (rd.peer == id_q);
  assign sts_o.expired  = (sat_elapsed >= rd.limit);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Build the result word
  always_comb begin
    res_status = ctl_i.res_status;
    res_peer   = id_q;
    res_handle = '0;
    res_count  = '0;
    res_last   = 1'b1;
    case (ctl_i.res_kind)
      kat_pkg::RES_SINGLE: begin
        if (ctl_i.with_handle) begin
          res_handle = ent_q.handle;
        end
      end
      kat_pkg::RES_EXPIRED: begin
        res_status = kat_pkg::STS_EXPIRED;
        res_peer   = ent_q.peer;
        res_last   = 1'b0;
      end
      kat_pkg::RES_CLOSE: begin
        res_status = kat_pkg::STS_OK;
        res_count  = xcnt_q;
      end
      default: res_last = 1'b1;
    endcase
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_status_q <= res_status;
      out_peer_q   <= res_peer;
      out_handle_q <= res_handle;
      out_count_q  <= res_count;
      out_last_q   <= res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign result_peer_o   = out_peer_q;
  assign result_handle_o = out_handle_q;
  assign expired_count_o = out_count_q;
  assign last_o          = out_last_q;

endmodule

@@ rtl/core/keepalive_timeout_table_core.sv @@
// Each command is taken in one word and answered through a one-word output register.
// The walk starts at entry 0: a full add or an empty tick is answered without a walk, an unused
// code gives no word, lookup, refresh or duplicate add stop at the match, delete also moves the
// last entry, a miss or new add walks every held entry, and a tick walks them all, with a word per expiry.
// Each entry takes a read and a compare, since the table RAM has a registered read.
// Reset clears the fill count and control only; table contents are left unwritten.
module keepalive_timeout_table_core #(
  parameter int CAPACITY = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  kat_in_if.sink          in_i,
  kat_out_if.source       out_o
);

  kat_pkg::dp_ctl_t ctl;
  kat_pkg::dp_sts_t sts;

  kat_ctrl u_kat_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  kat_datapath #(
    .CAPACITY (CAPACITY)
  ) u_kat_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .command_i       (in_i.command),
    .peer_id_i       (in_i.peer_id),
    .timeout_limit_i (in_i.timeout_limit),
    .timer_handle_i  (in_i.timer_handle),
    .tick_delta_i    (in_i.tick_delta),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .status_o        (out_o.status),
    .result_peer_o   (out_o.result_peer),
    .result_handle_o (out_o.result_handle),
    .expired_count_o (out_o.expired_count),
    .last_o          (out_o.last)
  );

endmodule

@@ rtl/core/kat_checker.sv @@
`include "keepalive_timeout_table_core_macros.svh"

module kat_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [kat_pkg::STS_W-1:0]   status_i,
  input logic [kat_pkg::ID_W-1:0]    result_peer_i,
  input logic [kat_pkg::HDL_W-1:0]   result_handle_i,
  input logic [kat_pkg::COUNT_W-1:0] expired_count_i,
  input logic                        last_i
);

  // A stalled result word holds
  `KAT_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, {status_i, result_peer_i, result_handle_i, expired_count_i, last_i})

  // One command at a time: ready drops after a word is taken
  `KAT_ASSERT(a_in_one, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i)

  // Expired reports never close a command
  `KAT_ASSERT(a_exp_open, clk_i, rst_ni, (out_valid_i && status_i == kat_pkg::STS_EXPIRED) |-> !last_i)

  // Every other status closes its command
  `KAT_ASSERT(a_other_last, clk_i, rst_ni, (out_valid_i && status_i != kat_pkg::STS_EXPIRED) |-> last_i)

  // A nonzero expiry count only on a closing tick summary
  `KAT_ASSERT(a_count_ok, clk_i, rst_ni, (out_valid_i && expired_count_i != '0) |-> (status_i == kat_pkg::STS_OK && last_i))

endmodule

bind keepalive_timeout_table_core kat_checker u_kat_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .result_peer_i   (out_o.result_peer),
  .result_handle_i (out_o.result_handle),
  .expired_count_i (out_o.expired_count),
  .last_i          (out_o.last)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int CAPACITY       = 32;
  localparam int CLK_PERIOD_NS  = 4;
  localparam int POOL_SIZE      = 64;
  localparam int PHASE_ITEMS    = 155;
  // Covers the longest tick: a read and a compare per entry, plus a result word per expired entry
  localparam int DRAIN_CYCLES   = 4 * CAPACITY + 64;
  localparam int TIMEOUT_CYCLES = 1_500_000;

  // Command codes the block ignores
  localparam logic [kat_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [kat_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [kat_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef struct packed {
    logic [kat_pkg::CMD_W-1:0] cmd;
    logic [kat_pkg::ID_W-1:0]  peer;
    logic [kat_pkg::LIM_W-1:0] limit;
    logic [kat_pkg::HDL_W-1:0] handle;
    logic [kat_pkg::LIM_W-1:0] delta;
  } cmd_word_t;

  typedef struct packed {
    logic [kat_pkg::STS_W-1:0]   status;
    logic [kat_pkg::ID_W-1:0]    peer;
    logic [kat_pkg::HDL_W-1:0]   handle;
    logic [kat_pkg::COUNT_W-1:0] count;
    logic                        last;
  } table_result_t;

  typedef struct packed {
    cmd_word_t                 word;
    bit                        typed;
    logic [kat_pkg::STS_W-1:0] status;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  kat_in_if  in_if ();
  kat_out_if out_if ();

  keepalive_timeout_table_core #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the peer table
  int                        table_fill;
  logic [kat_pkg::ID_W-1:0]  table_peer    [CAPACITY];
  logic [kat_pkg::LIM_W-1:0] table_limit   [CAPACITY];
  logic [kat_pkg::LIM_W-1:0] table_elapsed [CAPACITY];
  logic [kat_pkg::HDL_W-1:0] table_handle  [CAPACITY];

  table_result_t awaited_results [$];
  table_result_t new_results [$];
  table_result_t result_head;
  directed_row_t directed_rows [$];

  logic [kat_pkg::ID_W-1:0] peer_pool [POOL_SIZE];
  int  fail_count;
  int  src_idle_pct;
  int  snk_idle_pct;
  bit  fill_mode;
  bit  drain_mode;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD_NS / 2) clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD_NS);
    $display("** keepalive_timeout_table_core: FAILED **");
    $finish;
  end

  // Randomly stall the result side
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result word: status %0d, result_peer %08h",
               out_if.status, out_if.result_peer);
        fail_count++;
      end else begin
        result_head = awaited_results.pop_front();
        if (out_if.status !== result_head.status) begin
          $error("status: expected %0d, actual %0d", result_head.status, out_if.status);
          fail_count++;
        end
        if (out_if.result_peer !== result_head.peer) begin
          $error("result_peer: expected %08h, actual %08h",
                 result_head.peer, out_if.result_peer);
          fail_count++;
        end
        if (out_if.result_handle !== result_head.handle) begin
          $error("result_handle: expected %016h, actual %016h",
                 result_head.handle, out_if.result_handle);
          fail_count++;
        end
        if (out_if.expired_count !== result_head.count) begin
          $error("expired_count: expected %0d, actual %0d",
                 result_head.count, out_if.expired_count);
          fail_count++;
        end
        if (out_if.last !== result_head.last) begin
          $error("last: expected %0d, actual %0d", result_head.last, out_if.last);
          fail_count++;
        end
      end
    end
  end

  function automatic bit find_peer(input logic [kat_pkg::ID_W-1:0] id, output int slot);
    slot = 0;
    for (int i = 0; i < table_fill; i++) begin
      if (table_peer[i] == id) begin
        slot = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Work out the result words of one command and update the shadow table
  task automatic predict_results(input cmd_word_t w);
    int                      slot;
    int                      tail;
    int                      expired;
    logic [kat_pkg::LIM_W:0] sum;
    table_result_t           res;
    new_results.delete();
    res = '{status: kat_pkg::STS_OK, peer: w.peer, handle: '0, count: '0, last: 1'b1};
    case (w.cmd)
      kat_pkg::CMD_ADD: begin
        if (table_fill >= CAPACITY) begin
          res.status = kat_pkg::STS_FULL;
        end else if (find_peer(w.peer, slot)) begin
          res.status = kat_pkg::STS_PRESENT;
        end else begin
          table_peer[table_fill]    = w.peer;
          table_limit[table_fill]   = w.limit;
          table_elapsed[table_fill] = '0;
          table_handle[table_fill]  = w.handle;
          table_fill++;
        end
        new_results.push_back(res);
      end
      kat_pkg::CMD_DELETE: begin
        if (!find_peer(w.peer, slot)) begin
          res.status = kat_pkg::STS_NOT_FOUND;
        end else begin
          // move the tail entry into the hole
          tail = table_fill - 1;
          table_peer[slot]    = table_peer[tail];
          table_limit[slot]   = table_limit[tail];
          table_elapsed[slot] = table_elapsed[tail];
          table_handle[slot]  = table_handle[tail];
          table_fill          = tail;
        end
        new_results.push_back(res);
      end
      kat_pkg::CMD_REFRESH: begin
        if (!find_peer(w.peer, slot)) res.status = kat_pkg::STS_NOT_FOUND;
        else table_elapsed[slot] = '0;
        new_results.push_back(res);
      end
      kat_pkg::CMD_LOOKUP: begin
        if (!find_peer(w.peer, slot)) res.status = kat_pkg::STS_NOT_FOUND;
        else res.handle = table_handle[slot];
        new_results.push_back(res);
      end
      kat_pkg::CMD_TICK: begin
        if (table_fill == 0) begin
          res.status = kat_pkg::STS_EMPTY;
        end else begin
          expired = 0;
          for (int i = 0; i < table_fill; i++) begin
            // advance with saturation, then report entries at or past their limit
            sum = {1'b0, table_elapsed[i]} + {1'b0, w.delta};
            table_elapsed[i] = sum[kat_pkg::LIM_W] ? kat_pkg::ELAPSED_MAX
                                                   : sum[kat_pkg::LIM_W-1:0];
            if (table_elapsed[i] >= table_limit[i]) begin
              new_results.push_back('{status: kat_pkg::STS_EXPIRED, peer: table_peer[i],
                                      handle: '0, count: '0, last: 1'b0});
              expired++;
            end
          end
          res.count = expired[kat_pkg::COUNT_W-1:0];
        end
        new_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Offer one command word, with a random gap in front, and hold it until taken
  task automatic send_word(input cmd_word_t w);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_if.valid         <= 1'b1;
    in_if.command       <= w.cmd;
    in_if.peer_id       <= w.peer;
    in_if.timeout_limit <= w.limit;
    in_if.timer_handle  <= w.handle;
    in_if.tick_delta    <= w.delta;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic issue(input cmd_word_t w, input bit typed,
                       input logic [kat_pkg::STS_W-1:0] status);
    send_word(w);
    predict_results(w);
    if (typed) begin
      awaited_results.push_back('{status: status, peer: w.peer, handle: '0,
                                  count: '0, last: 1'b1});
    end else begin
      foreach (new_results[i]) awaited_results.push_back(new_results[i]);
    end
  endtask

  function automatic directed_row_t step_row(
    input logic [kat_pkg::CMD_W-1:0] cmd,
    input logic [kat_pkg::ID_W-1:0]  peer,
    input logic [kat_pkg::LIM_W-1:0] limit,
    input logic [kat_pkg::HDL_W-1:0] handle,
    input logic [kat_pkg::LIM_W-1:0] delta,
    input bit                        typed,
    input logic [kat_pkg::STS_W-1:0] status
  );
    directed_row_t row;
    row.word   = '{cmd: cmd, peer: peer, limit: limit, handle: handle, delta: delta};
    row.typed  = typed;
    row.status = status;
    return row;
  endfunction

  // Build a random command word; mostly known peers, with fill and drain runs
  task automatic random_word(output cmd_word_t w);
    int r;
    w.handle = {$urandom, $urandom};
    w.limit  = kat_pkg::LIM_W'($urandom);
    w.delta  = kat_pkg::LIM_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 45 && table_fill != 0) w.peer = table_peer[$urandom_range(0, table_fill - 1)];
    else if (r < 95) w.peer = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
    else w.peer = $urandom;

    if (fill_mode) begin
      // add until full, then one add that is turned away
      w.cmd = kat_pkg::CMD_ADD;
      w.peer = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (table_fill >= CAPACITY) fill_mode = 1'b0;
    end else if (drain_mode) begin
      // delete until empty, then tick the empty table
      if (table_fill == 0) begin
        w.cmd = kat_pkg::CMD_TICK;
        drain_mode = 1'b0;
      end else begin
        w.cmd = kat_pkg::CMD_DELETE;
        w.peer = table_peer[$urandom_range(0, table_fill - 1)];
      end
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) fill_mode = 1'b1;
      else if (r < 4) drain_mode = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 30) w.cmd = kat_pkg::CMD_ADD;
      else if (r < 48) w.cmd = kat_pkg::CMD_DELETE;
      else if (r < 62) w.cmd = kat_pkg::CMD_REFRESH;
      else if (r < 77) w.cmd = kat_pkg::CMD_LOOKUP;
      else if (r < 95) w.cmd = kat_pkg::CMD_TICK;
      else w.cmd = kat_pkg::CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
    end

    // Keep limits and deltas mostly small so expiry is common but not constant
    r = $urandom_range(0, 9);
    if (w.cmd == kat_pkg::CMD_ADD) begin
      if (r == 0) w.limit = '0;
      else if (r == 1) w.limit = '1;
      else if (r > 3) w.limit = kat_pkg::LIM_W'($urandom_range(0, 300));
    end
    if (w.cmd == kat_pkg::CMD_TICK) begin
      if (r == 0) w.delta = '0;
      else if (r == 1) w.delta = '1;
      else if (r > 3) w.delta = kat_pkg::LIM_W'($urandom_range(0, 60));
    end
  endtask

  // Main stimulus
  initial begin
    cmd_word_t w;
    int        done;

    fail_count   = 0;
    table_fill   = 0;
    fill_mode    = 1'b0;
    drain_mode   = 1'b0;
    src_idle_pct = 35;
    snk_idle_pct = 80;
    foreach (peer_pool[i]) peer_pool[i] = $urandom;
    peer_pool[0] = '0;
    peer_pool[1] = '1;

    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.command       <= kat_pkg::CMD_ADD;
    in_if.peer_id       <= '0;
    in_if.timeout_limit <= '0;
    in_if.timer_handle  <= '0;
    in_if.tick_delta    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extremes, rejections, expiry, saturation, spare codes
    directed_rows.push_back(step_row(kat_pkg::CMD_TICK,    '1,   0, 0, '1, 1,
                                     kat_pkg::STS_EMPTY));
    directed_rows.push_back(step_row(kat_pkg::CMD_LOOKUP,  '0,   0, 0, 0, 1,
                                     kat_pkg::STS_NOT_FOUND));
    directed_rows.push_back(step_row(kat_pkg::CMD_DELETE,  32'h1234_5678, 0, 0, 0, 1,
                                     kat_pkg::STS_NOT_FOUND));
    directed_rows.push_back(step_row(kat_pkg::CMD_REFRESH, '1,   0, 0, 0, 1,
                                     kat_pkg::STS_NOT_FOUND));
    directed_rows.push_back(step_row(kat_pkg::CMD_ADD,     '0,   0, '1, 0, 1,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_ADD,     '0,   7, 1, 0, 1,
                                     kat_pkg::STS_PRESENT));
    directed_rows.push_back(step_row(kat_pkg::CMD_ADD,     '1,  '1, 0, 0, 1,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_ADD,     32'd5, 10,
                                     64'hA5A5_5A5A_F00D_0001, 0, 1, kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_LOOKUP,  '0,   0, 0, 0, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_LOOKUP,  '1,   0, 0, 0, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_TICK,    32'hCAFE_0001, 0, 0, 0, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_TICK,    '0,   0, 0, 10, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_TICK,    '1,   0, 0, '1, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_TICK,    32'd7, 0, 0, '1, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_REFRESH, 32'd5, 0, 0, 0, 1,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_TICK,    32'd2, 0, 0, 9, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_DELETE,  '0,   0, 0, 0, 1,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_LOOKUP,  32'd5, 0, 0, 0, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(CMD_RSVD5,            32'd5, '1, '1, '1, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(CMD_RSVD6,            '1,   0, 0, 0, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(CMD_RSVD7,            '0,   0, 0, 0, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_TICK,    32'd3, 0, 0, 1, 0,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_DELETE,  '1,   0, 0, 0, 1,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_DELETE,  32'd5, 0, 0, 0, 1,
                                     kat_pkg::STS_OK));
    directed_rows.push_back(step_row(kat_pkg::CMD_TICK,    '1,   0, 0, 1, 1,
                                     kat_pkg::STS_EMPTY));
    foreach (directed_rows[i])
      issue(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].status);

    // Random: receiver-heavy idling, then sender-heavy, then none
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 80 : 0;
      snk_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 35 : 0;
      done = 0;
      while (done < PHASE_ITEMS) begin
        if (done == PHASE_ITEMS / 3) fill_mode = 1'b1;
        if (done == 2 * PHASE_ITEMS / 3 && !fill_mode) drain_mode = 1'b1;
        random_word(w);
        issue(w, 1'b0, kat_pkg::STS_OK);
        if (w.cmd <= kat_pkg::CMD_LOOKUP) done++;
      end
    end
    in_if.valid <= 1'b0;

    // Drain: wait for every expected word, then watch for strays
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** keepalive_timeout_table_core: PASSED **");
    end else begin
      $display("** keepalive_timeout_table_core: FAILED **");
    end
    $finish;
  end

endmodule
